>>> hw/rtl/icme_pkg.sv
// shared constants and types for the interleaved channel min/max envelope
package icme_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF  = 24;

  // register widths
  localparam int TC_W       = 7;
  localparam int CI_W       = 6;
  localparam int SPP_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [TC_W-1:0]  MAX_CHANNELS   = TC_W'(64);
  localparam logic [TC_W-1:0]  TC_RESET       = TC_W'(1);
  localparam logic [CI_W-1:0]  CI_RESET       = '0;
  localparam logic [SPP_W-1:0] SPP_RESET      = SPP_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_CHANNELS    = 2'd0,
    REG_CHANNEL_INDEX     = 2'd1,
    REG_SAMPLES_PER_POINT = 2'd2
  } cfg_reg_t;

  // result buffer status seen by the top level
  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

endpackage

>>> hw/rtl/icme_core.sv
// configuration registers, stream state and min/max fold for one word per cycle while step is high
module icme_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [icme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icme_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                step,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                last,
  output logic                                emit,
  output logic signed [SAMPLE_BITS-1:0]       min_value,
  output logic [SAMPLE_BITS-2:0]              max_value,
  output logic                                last_point
);
  import icme_pkg::*;

  logic [TC_W-1:0]  total_channels;
  logic [CI_W-1:0]  channel_index;
  logic [SPP_W-1:0] samples_per_point;

  logic [CI_W-1:0]               frame_position;
  logic [COUNT_BITS-1:0]         frames_in_bucket;
  logic signed [SAMPLE_BITS-1:0] running_min;
  logic [SAMPLE_BITS-2:0]        running_max;
  logic signed [SAMPLE_BITS-1:0] held_sample;

  logic [TC_W-1:0]               chans_eff;
  logic [TC_W-1:0]               last_pos;
  logic [COUNT_BITS-1:0]         spp_masked;
  logic [COUNT_BITS-1:0]         spp_eff;
  logic signed [SAMPLE_BITS-1:0] held_next;
  logic                          frame_done;
  logic                          chan_ok;
  logic signed [SAMPLE_BITS-1:0] fold_min;
  logic [SAMPLE_BITS-2:0]        fold_max;
  logic [COUNT_BITS-1:0]         fib_inc;
  logic [COUNT_BITS-1:0]         fib_fold;
  logic                          bucket_done;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      total_channels    <= TC_RESET;
      channel_index     <= CI_RESET;
      samples_per_point <= SPP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOTAL_CHANNELS:    total_channels    <= cfg_data[TC_W-1:0];
        REG_CHANNEL_INDEX:     channel_index     <= cfg_data[CI_W-1:0];
        REG_SAMPLES_PER_POINT: samples_per_point <= cfg_data[SPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (total_channels == '0) begin
      chans_eff = TC_W'(1);
    end else if (total_channels > MAX_CHANNELS) begin
      chans_eff = MAX_CHANNELS;
    end else begin
      chans_eff = total_channels;
    end
    last_pos   = chans_eff - TC_W'(1);
    spp_masked = COUNT_BITS'(samples_per_point);
    spp_eff    = (spp_masked == '0) ? COUNT_BITS'(1) : spp_masked;

    held_next  = (frame_position == channel_index) ? sample : held_sample;
    frame_done = {1'b0, frame_position} >= last_pos;
    chan_ok    = {1'b0, channel_index} < chans_eff;

    fold_min = running_min;
    fold_max = running_max;
    if (frame_done && chan_ok) begin
      if (held_next < running_min) begin
        fold_min = held_next;
      end
      if (!held_next[SAMPLE_BITS-1] && (held_next[SAMPLE_BITS-2:0] > running_max)) begin
        fold_max = held_next[SAMPLE_BITS-2:0];
      end
    end

    fib_inc     = frames_in_bucket + COUNT_BITS'(1);
    fib_fold    = frame_done ? fib_inc : frames_in_bucket;
    bucket_done = frame_done && (fib_inc >= spp_eff);

    emit       = step && (bucket_done || (last && (fib_fold != '0)));
    min_value  = fold_min;
    max_value  = fold_max;
    last_point = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position   <= '0;
      frames_in_bucket <= '0;
      running_min      <= '0;
      running_max      <= '0;
      held_sample      <= '0;
    end else if (step) begin
      held_sample <= held_next;
      frame_position <= (frame_done || last) ? '0 : frame_position + CI_W'(1);
      if (bucket_done || last) begin
        frames_in_bucket <= '0;
        running_min      <= '0;
        running_max      <= '0;
      end else begin
        frames_in_bucket <= fib_fold;
        running_min      <= fold_min;
        running_max      <= fold_max;
      end
    end
  end

`ifndef SYNTH
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && last |=> frame_position == '0 && frames_in_bucket == '0 &&
                     running_min == '0 && running_max == '0)
    else $error("stream end did not clear the envelope state");
  a_emit_on_step: assert property (@(posedge clk) disable iff (rst)
    emit |-> step)
    else $error("point emitted without a word");
  a_min_not_positive: assert property (@(posedge clk) disable iff (rst)
    running_min[SAMPLE_BITS-1] || running_min == '0)
    else $error("running minimum above zero");
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(frame_position) && $stable(frames_in_bucket))
    else $error("stream position moved without a word");
`endif

endmodule

>>> hw/rtl/icme_out_fifo.sv
// two-entry result buffer between the fold logic and the master port
module icme_out_fifo #(
  parameter int WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head_data,
  output icme_pkg::fifo_stat_t  stat
);
  import icme_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop_ok;

  assign pop_ok         = pop && (count != 2'd0);
  assign head_data      = mem[rd_ptr];
  assign stat.full      = (count == 2'd2);
  assign stat.not_empty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2 && !pop_ok))
    else $error("result pushed into a full buffer");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    count == 2'd1 && pop_ok && !push |=> count == 2'd0)
    else $error("result buffer did not drain");
`endif

endmodule

>>> hw/rtl/interleaved_channel_minmax_envelope_top.sv
// top level of the interleaved channel min/max envelope
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata sample, s_tlast end of stream
// m_*       out        m_tvalid/m_tready  m_tdata min/max, m_tlast final point
// cfg_*     in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one word per cycle unless the result buffer is full and m_tready is low: each beat is
// caught in an input register and folded into the stream state once the buffer has room,
// by one compare per bound and one counter step; points reach m_tdata from the buffer
// a two-entry result buffer lets words keep flowing while a point waits
// rst clears stream state and loads the register defaults (one channel,
// channel 0, one frame per point); nothing needs a clearing pass
// s_tready drops only while the result buffer is full and m_tready is low
module interleaved_channel_minmax_envelope_top #(
  parameter int SAMPLE_BITS = icme_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = icme_pkg::COUNT_BITS_DEF,
  localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int M_TDATA_W  = ((2 * SAMPLE_BITS - 1 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [S_TDATA_W-1:0]             s_tdata,   // sample, zero padding
  input  logic                             s_tlast,
  // envelope points
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [M_TDATA_W-1:0]             m_tdata,   // min_value, max_value, zero padding
  output logic                             m_tlast,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [icme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icme_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import icme_pkg::*;

  localparam int RES_W = 2 * SAMPLE_BITS;

  // input register
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_last;

  logic                          fire;
  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] min_value;
  logic [SAMPLE_BITS-2:0]        max_value;
  logic                          last_point;
  logic [RES_W-1:0]              head_data;
  fifo_stat_t                    fifo_stat;

  // a word is folded when the buffer has room, counting a pop this cycle
  assign fire      = in_valid && (!fifo_stat.full || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      in_last   <= s_tlast;
    end
  end

  icme_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (fire),
    .sample     (in_sample),
    .last       (in_last),
    .emit       (emit),
    .min_value  (min_value),
    .max_value  (max_value),
    .last_point (last_point)
  );

  icme_out_fifo #(
    .WIDTH (RES_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data ({last_point, max_value, min_value}),
    .pop       (m_tready),
    .head_data (head_data),
    .stat      (fifo_stat)
  );

  assign m_tvalid = fifo_stat.not_empty;
  assign m_tdata  = M_TDATA_W'(head_data[RES_W-2:0]);
  assign m_tlast  = head_data[RES_W-1];

endmodule
